>>> sv/asfe_pkg.sv
package asfe_pkg;

  // Register indexes on the configuration port
  localparam logic CfgAmplitude = 1'b0;
  localparam logic CfgBitLen    = 1'b1;

  localparam int AmpW      = 15;
  localparam int SampleW   = 16;
  localparam int BitLenW   = 3;
  localparam int ByteW     = 8;
  localparam int ByteIdxW  = 3;
  localparam int MaxBitLen = 4;
  localparam int RepW      = 2;
  localparam int QueueDepth = 2;

  localparam logic [AmpW-1:0]    AmplitudeReset = 15'd16384;
  localparam logic [BitLenW-1:0] BitLenReset    = 3'd4;

  // One classified frame request between front and back
  typedef struct packed {
    logic [ByteW-1:0] char_byte;
    logic             no_data;
    logic [RepW-1:0]  len_m1;
  } frame_req_t;

endpackage

>>> sv/asfe_front.sv
module asfe_front
  import asfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   char_byte,
  input  logic               no_data,
  input  logic [BitLenW-1:0] bit_len,
  output logic               req_valid,
  input  logic               req_ready,
  output frame_req_t         req
);

  logic       valid_r, valid_nxt;
  frame_req_t req_r, req_nxt;
  logic [RepW-1:0] len_m1;

  // Clamp slot length to 1..MaxBitLen, kept as length minus one
  always_comb begin
    priority if (bit_len == '0) begin
      len_m1 = '0;
    end else if (bit_len > BitLenW'(MaxBitLen)) begin
      len_m1 = RepW'(MaxBitLen - 1);
    end else begin
      len_m1 = RepW'(bit_len - 1'b1);
    end
  end

  assign in_ready = !valid_r || req_ready;

  // Take a new item whenever the stage is empty or the held one moves on
  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      req_nxt   = '{char_byte: char_byte, no_data: no_data, len_m1: len_m1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

>>> sv/asfe_queue.sv
module asfe_queue
  import asfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_req_t push_req,
  output logic       pop_valid,
  input  logic       pop_ready,
  output frame_req_t pop_req
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  frame_req_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic push, pop;

  assign push_ready = count_r != CntW'(QueueDepth);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_req    = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> sv/asfe_back.sv
module asfe_back
  import asfe_pkg::*;
#(
  parameter int DATA_BITS  = 8,
  parameter int WAIT_SLOTS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [AmpW-1:0]    amplitude,
  input  logic               req_valid,
  output logic               req_ready,
  input  frame_req_t         req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SampleW-1:0] left_sample,
  output logic [SampleW-1:0] right_sample,
  output logic               last_sample
);

  localparam int Slots = 2 + DATA_BITS + WAIT_SLOTS;
  localparam int SlotW = $clog2(Slots);
  localparam logic [SlotW-1:0] StopSlot = SlotW'(DATA_BITS + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Slots - 1);

  logic busy_r, busy_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic [RepW-1:0]  rep_r, rep_nxt;
  frame_req_t cur_r, cur_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] left_r, left_nxt, right_r, right_nxt;
  logic last_r, last_nxt;

  logic advance, last_w, pop;
  logic [SampleW-1:0] pos_amp, neg_amp, left_w, right_w;
  logic [ByteIdxW-1:0] bit_idx;

  assign advance   = !out_valid_r || out_ready;
  assign last_w    = (slot_r == LastSlot) && (rep_r == cur_r.len_m1);
  assign pop       = req_valid && (!busy_r || (advance && last_w));
  assign req_ready = !busy_r || (advance && last_w);

  // Form the two levels and pick the data channel sample for this slot
  assign pos_amp = {1'b0, amplitude};
  assign neg_amp = SampleW'(0) - pos_amp;
  assign bit_idx = ByteIdxW'(slot_r - 1'b1);

  always_comb begin
    priority if (cur_r.no_data || slot_r > StopSlot) begin
      left_w = '0;
    end else if (slot_r == '0) begin
      left_w = pos_amp;
    end else if (slot_r == StopSlot) begin
      left_w = neg_amp;
    end else begin
      left_w = cur_r.char_byte[bit_idx] ? neg_amp : pos_amp;
    end
  end

  assign right_w = slot_r[0] ? pos_amp : neg_amp;

  // Step through slots and repeats; load the next frame when idle or on the last sample
  always_comb begin
    busy_nxt      = busy_r;
    slot_nxt      = slot_r;
    rep_nxt       = rep_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = busy_r;
      left_nxt      = left_w;
      right_nxt     = right_w;
      last_nxt      = last_w;
    end
    if (pop) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
      rep_nxt  = '0;
      cur_nxt  = req;
    end else if (advance && busy_r) begin
      if (last_w) begin
        busy_nxt = 1'b0;
      end else if (rep_r == cur_r.len_m1) begin
        rep_nxt  = '0;
        slot_nxt = slot_r + 1'b1;
      end else begin
        rep_nxt = rep_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      rep_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
      rep_r       <= rep_nxt;
    end
    cur_r   <= cur_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign left_sample  = left_r;
  assign right_sample = right_r;
  assign last_sample  = last_r;

`ifndef NO_ASSERTIONS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> slot_r <= LastSlot)
    else $error("slot counter past end of frame");

  a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rep_r <= cur_r.len_m1)
    else $error("repeat counter past slot length");

  a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && advance && !last_w) |=> busy_r)
    else $error("frame dropped before its last sample");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && advance && last_w) |=> (out_valid_r && last_r))
    else $error("last sample of frame not presented");
`endif

endmodule

>>> sv/audio_serial_frame_encoder.sv
// The first sample pair of a frame, when the block is empty, passes through the input stage,
// the queue, the back end's frame register and the output register after its item is accepted.
// Throughput: one sample pair per cycle while out_tready is high; a frame holds (2 + DATA_BITS +
// WAIT_SLOTS) * bit_len pairs (16 to 64 at the defaults), set by the slot and repeat counters.
// A new item is taken every frame with no gap between frames.
// Reset (rst_n low, synchronous) empties the pipeline and restores amplitude and bit_len.
module audio_serial_frame_encoder
  import asfe_pkg::*;
#(
  parameter int DATA_BITS  = 8,
  parameter int WAIT_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,   // [7:0] char_byte
  input  logic                 in_tuser,   // [0] no_data
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*SampleW-1:0] out_tdata,  // [15:0] left_sample, [31:16] right_sample
  output logic                 out_tlast,  // last_sample
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [AmpW-1:0]      cfg_wdata
);

  logic [AmpW-1:0]    amplitude_r;
  logic [BitLenW-1:0] bit_len_r;

  logic       f_valid, f_ready, b_valid, b_ready;
  frame_req_t f_req, b_req;
  logic [SampleW-1:0] left_sample, right_sample;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= AmplitudeReset;
      bit_len_r   <= BitLenReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgAmplitude: amplitude_r <= cfg_wdata;
        CfgBitLen:    bit_len_r   <= cfg_wdata[BitLenW-1:0];
        default:      ;
      endcase
    end
  end

  asfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .char_byte (in_tdata),
    .no_data   (in_tuser),
    .bit_len   (bit_len_r),
    .req_valid (f_valid),
    .req_ready (f_ready),
    .req       (f_req)
  );

  asfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_req   (f_req),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_req    (b_req)
  );

  asfe_back #(
    .DATA_BITS  (DATA_BITS),
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .amplitude    (amplitude_r),
    .req_valid    (b_valid),
    .req_ready    (b_ready),
    .req          (b_req),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_sample  (out_tlast)
  );

  assign out_tdata = {right_sample, left_sample};

endmodule

>>> dv/audio_serial_frame_encoder_tb.sv
`timescale 1ns / 100ps

module audio_serial_frame_encoder_tb;
  import asfe_pkg::*;

  localparam int NBits      = 8;
  localparam int WaitSlots  = 6;
  localparam int FrameSlots = 2 + NBits + WaitSlots;
  localparam int DrainCycles = 8;
  localparam int RandPhases  = 10;
  localparam int PhaseItems  = 37;

  typedef enum logic { RowItem, RowWrite } row_kind_t;

  // One sample pair as it should leave the block
  typedef struct {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      last;
  } sample_pair_t;

  // Hand-written expectation for a whole frame: first pair and length
  typedef struct {
    bit                        typed;
    logic signed [SampleW-1:0] first_left;
    logic signed [SampleW-1:0] first_right;
    int                        pairs;
  } frame_ref_t;

  typedef struct {
    row_kind_t        kind;
    logic             reg_idx;
    logic [AmpW-1:0]  value;   // register value, or char_byte in the low bits
    logic             idle;
    frame_ref_t       fref;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [ByteW-1:0]     in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [2*SampleW-1:0] out_tdata;
  logic                 out_tlast;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [AmpW-1:0]      cfg_wdata;

  // Shadow copy of the registers
  logic [AmpW-1:0]    amp_shadow;
  logic [BitLenW-1:0] bitlen_shadow;

  sample_pair_t pending_pairs[$];
  frame_ref_t   frame_refs[$];
  stim_row_t    dir_rows[$];
  frame_ref_t   cur_ref;
  int           pair_pos;

  int  errors;
  int  n_items;
  int  n_idle;
  int  n_writes;
  int  n_pairs;
  bit  calm;
  int  ready_hold;

  audio_serial_frame_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  // Alternate between stretches with gaps and stretches without
  initial begin
    forever begin
      calm = 1'b0;
      repeat ($urandom_range(300, 900)) @(negedge clk);
      calm = 1'b1;
      repeat ($urandom_range(100, 300)) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic signed [SampleW-1:0] level_of(bit pos, logic [AmpW-1:0] mag);
    logic signed [SampleW-1:0] m;
    m = {1'b0, mag};
    return pos ? m : -m;
  endfunction

  // Build every sample pair of one frame and queue them in order
  function automatic void predict_frame(logic [ByteW-1:0] b, logic idle);
    int           len;
    sample_pair_t p;
    len = bitlen_shadow;
    if (len == 0) len = 1;
    if (len > MaxBitLen) len = MaxBitLen;
    for (int s = 0; s < FrameSlots; s++) begin
      p.right = level_of(s[0], amp_shadow);
      if (idle || s > NBits + 1)
        p.left = '0;
      else if (s == 0)
        p.left = level_of(1'b1, amp_shadow);
      else if (s == NBits + 1)
        p.left = level_of(1'b0, amp_shadow);
      else
        p.left = level_of(!b[s-1], amp_shadow);
      for (int k = 0; k < len; k++) begin
        p.last = (s == FrameSlots - 1) && (k == len - 1);
        pending_pairs.push_back(p);
      end
    end
  endfunction

  function automatic stim_row_t write_row(logic idx, logic [AmpW-1:0] val);
    stim_row_t r;
    r = '{kind: RowWrite, reg_idx: idx, value: val, idle: 1'b0, fref: '{0, 0, 0, 0}};
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [ByteW-1:0] b, logic idle);
    stim_row_t r;
    r = '{kind: RowItem, reg_idx: 1'b0, value: {7'd0, b}, idle: idle, fref: '{0, 0, 0, 0}};
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [ByteW-1:0] b, logic idle,
                                          int fl, int fr, int n);
    stim_row_t r;
    r = item_row(b, idle);
    r.fref = '{1'b1, fl[SampleW-1:0], fr[SampleW-1:0], n};
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [AmpW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CfgAmplitude)
      amp_shadow = val;
    else
      bitlen_shadow = val[BitLenW-1:0];
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the item until accepted, then record what it should produce
  task automatic send_item(logic [ByteW-1:0] b, logic idle, frame_ref_t fref);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= idle;
    do @(posedge clk); while (!in_tready);
    predict_frame(b, idle);
    frame_refs.push_back(fref);
    n_items++;
    if (idle) n_idle++;
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Output ready: random stalls, none starting during calm stretches
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        ready_hold <= pick_gap();
      end
    end
  end

  // Compare each accepted sample pair with the oldest expectation
  always @(posedge clk) begin : check_out
    sample_pair_t              exp_p;
    logic signed [SampleW-1:0] got_left;
    logic signed [SampleW-1:0] got_right;
    if (rst_n && out_tvalid && out_tready) begin
      got_left  = out_tdata[SampleW-1:0];
      got_right = out_tdata[2*SampleW-1:SampleW];
      if (pending_pairs.size() == 0) begin
        $error("unexpected item: left %0d right %0d last %0b", got_left, got_right,
               out_tlast);
        errors++;
      end else begin
        exp_p = pending_pairs.pop_front();
        if (got_left !== exp_p.left) begin
          $error("left_sample: expected %0d, got %0d", exp_p.left, got_left);
          errors++;
        end
        if (got_right !== exp_p.right) begin
          $error("right_sample: expected %0d, got %0d", exp_p.right, got_right);
          errors++;
        end
        if (out_tlast !== exp_p.last) begin
          $error("last_sample: expected %0b, got %0b", exp_p.last, out_tlast);
          errors++;
        end
      end
      // Frame-level check against the hand-written rows
      if (pair_pos == 0) begin
        if (frame_refs.size() != 0)
          cur_ref = frame_refs.pop_front();
        else
          cur_ref.typed = 1'b0;
        if (cur_ref.typed && got_left !== cur_ref.first_left) begin
          $error("left_sample: expected %0d, got %0d", cur_ref.first_left, got_left);
          errors++;
        end
        if (cur_ref.typed && got_right !== cur_ref.first_right) begin
          $error("right_sample: expected %0d, got %0d", cur_ref.first_right, got_right);
          errors++;
        end
      end
      pair_pos = pair_pos + 1;
      if (out_tlast) begin
        if (cur_ref.typed && pair_pos != cur_ref.pairs) begin
          $error("frame_length: expected %0d, got %0d", cur_ref.pairs, pair_pos);
          errors++;
        end
        pair_pos = 0;
      end
      n_pairs++;
    end
  end

  initial begin : main
    frame_ref_t       no_ref;
    logic [AmpW-1:0]  amp_v;
    logic [AmpW-1:0]  len_v;
    logic [ByteW-1:0] b;
    logic             idle;
    int               r;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = 1'b0;
    cfg_wdata  = '0;
    ready_hold = 0;
    pair_pos   = 0;
    errors     = 0;
    n_items    = 0;
    n_idle     = 0;
    n_writes   = 0;
    n_pairs    = 0;
    cur_ref    = '{0, 0, 0, 0};
    no_ref     = '{0, 0, 0, 0};
    amp_shadow    = AmplitudeReset;
    bitlen_shadow = BitLenReset;

    // Directed rows: reset values first, then the extremes of both registers
    dir_rows.push_back(typed_row(8'h00, 1'b0, 16384, -16384, 64));
    dir_rows.push_back(typed_row(8'hFF, 1'b0, 16384, -16384, 64));
    dir_rows.push_back(item_row(8'h55, 1'b0));
    dir_rows.push_back(item_row(8'hAA, 1'b0));
    dir_rows.push_back(typed_row(8'hFF, 1'b1, 0, -16384, 64));
    dir_rows.push_back(item_row(8'h01, 1'b0));
    dir_rows.push_back(item_row(8'h80, 1'b0));
    dir_rows.push_back(write_row(CfgAmplitude, 15'd32767));
    dir_rows.push_back(write_row(CfgBitLen, 15'd1));
    dir_rows.push_back(typed_row(8'h00, 1'b0, 32767, -32767, 16));
    dir_rows.push_back(typed_row(8'hFF, 1'b0, 32767, -32767, 16));
    dir_rows.push_back(typed_row(8'h00, 1'b1, 0, -32767, 16));
    // Bit length zero behaves as one
    dir_rows.push_back(write_row(CfgBitLen, 15'd0));
    dir_rows.push_back(typed_row(8'h5A, 1'b0, 32767, -32767, 16));
    // Silent amplitude; bit length above four behaves as four
    dir_rows.push_back(write_row(CfgAmplitude, 15'd0));
    dir_rows.push_back(write_row(CfgBitLen, 15'd7));
    dir_rows.push_back(typed_row(8'hFF, 1'b0, 0, 0, 64));
    dir_rows.push_back(typed_row(8'hAA, 1'b1, 0, 0, 64));
    dir_rows.push_back(write_row(CfgAmplitude, 15'd1));
    dir_rows.push_back(write_row(CfgBitLen, 15'd5));
    dir_rows.push_back(typed_row(8'h3C, 1'b0, 1, -1, 64));
    dir_rows.push_back(write_row(CfgBitLen, 15'd6));
    dir_rows.push_back(item_row(8'hC3, 1'b0));
    dir_rows.push_back(write_row(CfgAmplitude, 15'd12345));
    dir_rows.push_back(write_row(CfgBitLen, 15'd2));
    dir_rows.push_back(typed_row(8'h96, 1'b0, 12345, -12345, 32));
    dir_rows.push_back(typed_row(8'h69, 1'b1, 0, -12345, 32));
    dir_rows.push_back(write_row(CfgBitLen, 15'd3));
    dir_rows.push_back(typed_row(8'hE7, 1'b0, 12345, -12345, 48));
    dir_rows.push_back(item_row(8'h18, 1'b0));

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowWrite) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].value[ByteW-1:0], dir_rows[i].idle, dir_rows[i].fref);
      end
    end

    // Random phases, each with fresh register values
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 0) begin
        amp_v = 15'd32767;
        len_v = 15'd4;
      end else if (ph == 1) begin
        amp_v = 15'd0;
        len_v = 15'd1;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) amp_v = 15'd0;
        else if (r == 1) amp_v = 15'd1;
        else if (r == 2) amp_v = 15'd32767;
        else amp_v = AmpW'($urandom_range(0, 32767));
        // Upper write bits are don't-care for the bit length register
        len_v = AmpW'($urandom_range(0, 32767));
      end
      drain();
      write_reg(CfgAmplitude, amp_v);
      write_reg(CfgBitLen, len_v);
      for (int k = 0; k < PhaseItems; k++) begin
        r = $urandom_range(0, 11);
        if (r == 0) b = 8'h00;
        else if (r == 1) b = 8'hFF;
        else b = ByteW'($urandom_range(0, 255));
        idle = ($urandom_range(0, 5) == 0);
        send_item(b, idle, no_ref);
      end
    end

    drain();
    repeat (16) @(posedge clk);

    $display("Sent %0d items (%0d idle frames) across %0d register writes,", n_items,
             n_idle, n_writes);
    $display("bit lengths 0..7 and amplitudes 0 to full scale; %0d sample pairs checked",
             n_pairs);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> audio_serial_frame_encoder.f
sv/asfe_pkg.sv
sv/asfe_front.sv
sv/asfe_queue.sv
sv/asfe_back.sv
sv/audio_serial_frame_encoder.sv
dv/audio_serial_frame_encoder_tb.sv
